>>> design/ahc_pkg.sv
// Package for the acquisition handshake controller: beat types, phase and request codes,
// and period limits. Used by ahc_fsm and acquisition_handshake_controller.
// Has no dependencies.
package ahc_pkg;

    localparam int PERIOD_W = 24;
    localparam int CNT_W    = 32;
    localparam int TIME_IN_W = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000000 / 50);
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = PERIOD_W'(1);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(10000000);

    // Miss threshold is MISS_FACTOR periods.
    localparam int MISS_FACTOR = 2;
    localparam int MISS_W      = PERIOD_W + 1;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_RESET = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ACQ    = 3'd1,
        PH_WREADY = 3'd2,
        PH_WACK   = 3'd3,
        PH_SEND   = 3'd4,
        PH_WDONE  = 3'd5
    } phase_t;

    typedef struct packed {
        req_t                 req_type;
        logic [TIME_IN_W-1:0] time_us;
        logic                 host_send;
        logic                 send_done;
    } item_t;

    typedef struct packed {
        logic             ready_level;
        logic             capture_stop;
        logic             capture_start;
        logic             buffer_swap;
        logic             send_request;
        logic [CNT_W-1:0] send_seq;
        logic             running;
        phase_t           phase;
        logic [CNT_W-1:0] miss_ready_count;
        logic [CNT_W-1:0] miss_ack_count;
    } result_t;

endpackage

>>> design/ahc_fsm.sv
// Control state and one-beat step logic of the acquisition handshake controller.
// Depends on ahc_pkg. State updates on each advanced beat; the result is combinational.
module ahc_fsm #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  ahc_pkg::item_t                  item,
    input  logic [ahc_pkg::PERIOD_W-1:0]    period,
    output ahc_pkg::result_t                result,
    output logic                            run_flag
);

    localparam int CMP_W = (TIME_WIDTH > ahc_pkg::MISS_W) ? TIME_WIDTH : ahc_pkg::MISS_W;

    ahc_pkg::phase_t              phase_reg, phase_next;
    logic [TIME_WIDTH-1:0]        last_time_reg, last_time_next;
    logic                         start_pend_reg, start_pend_next;
    logic                         stop_pend_reg, stop_pend_next;
    logic                         run_reg, run_next;
    logic                         ready_reg, ready_next;
    logic                         miss_rdy_flag_reg, miss_rdy_flag_next;
    logic                         miss_ack_flag_reg, miss_ack_flag_next;
    logic [ahc_pkg::CNT_W-1:0]    miss_rdy_total_reg, miss_rdy_total_next;
    logic [ahc_pkg::CNT_W-1:0]    miss_ack_total_reg, miss_ack_total_next;
    logic [ahc_pkg::CNT_W-1:0]    seq_reg, seq_next;

    logic [TIME_WIDTH-1:0]        now_w;
    logic [TIME_WIDTH-1:0]        elapsed;
    logic [ahc_pkg::MISS_W-1:0]   twice;
    logic                         over_period;
    logic                         over_twice;
    logic                         stop_in;
    logic                         cap_stop, cap_start, swap, send_req;

    assign now_w   = TIME_WIDTH'(item.time_us);
    // wrapping elapsed time at TIME_WIDTH bits
    assign elapsed = now_w - last_time_reg;
    assign twice   = ahc_pkg::MISS_W'(period) * ahc_pkg::MISS_W'(ahc_pkg::MISS_FACTOR);
    assign over_period = CMP_W'(elapsed) > CMP_W'(period);
    assign over_twice  = CMP_W'(elapsed) > CMP_W'(twice);
    assign stop_in     = stop_pend_reg || (item.req_type == ahc_pkg::REQ_RESET);

    always_comb begin
        phase_next          = phase_reg;
        last_time_next      = last_time_reg;
        start_pend_next     = start_pend_reg;
        stop_pend_next      = stop_pend_reg;
        run_next            = run_reg;
        ready_next          = ready_reg;
        miss_rdy_flag_next  = miss_rdy_flag_reg;
        miss_ack_flag_next  = miss_ack_flag_reg;
        miss_rdy_total_next = miss_rdy_total_reg;
        miss_ack_total_next = miss_ack_total_reg;
        seq_next            = seq_reg;
        cap_stop            = 1'b0;
        cap_start           = 1'b0;
        swap                = 1'b0;
        send_req            = 1'b0;

        if (item.req_type == ahc_pkg::REQ_START) begin
            last_time_next  = now_w;
            start_pend_next = 1'b1;
            cap_start       = 1'b1;
        end else if (item.req_type == ahc_pkg::REQ_STOP) begin
            stop_pend_next = 1'b1;
        end else begin
            // tick; a reset request ticks with stop pending, then forces idle
            stop_pend_next = stop_in;
            unique case (phase_reg)
                ahc_pkg::PH_IDLE: begin
                    run_next = 1'b0;
                    if (start_pend_reg) begin
                        phase_next      = ahc_pkg::PH_ACQ;
                        run_next        = 1'b1;
                        start_pend_next = 1'b0;
                    end
                    if (stop_in) begin
                        stop_pend_next = 1'b0;
                        run_next       = 1'b0;
                    end
                end
                ahc_pkg::PH_ACQ: begin
                    if (stop_in) begin
                        phase_next     = ahc_pkg::PH_IDLE;
                        stop_pend_next = 1'b0;
                    end else if (over_period) begin
                        cap_stop   = 1'b1;
                        phase_next = ahc_pkg::PH_WREADY;
                    end
                end
                ahc_pkg::PH_WREADY: begin
                    if (!item.host_send) begin
                        phase_next = ahc_pkg::PH_WACK;
                    end else if (!miss_rdy_flag_reg && over_twice) begin
                        miss_rdy_flag_next  = 1'b1;
                        miss_rdy_total_next = miss_rdy_total_reg + 1'b1;
                    end
                end
                ahc_pkg::PH_WACK: begin
                    ready_next = 1'b1;
                    if (item.host_send) begin
                        ready_next = 1'b0;
                        phase_next = ahc_pkg::PH_SEND;
                    end else if (!miss_ack_flag_reg && over_twice) begin
                        miss_ack_flag_next  = 1'b1;
                        miss_ack_total_next = miss_ack_total_reg + 1'b1;
                    end
                end
                ahc_pkg::PH_SEND: begin
                    swap               = 1'b1;
                    cap_start          = 1'b1;
                    send_req           = 1'b1;
                    last_time_next     = now_w;
                    seq_next           = seq_reg + 1'b1;
                    phase_next         = ahc_pkg::PH_WDONE;
                    miss_rdy_flag_next = 1'b0;
                    miss_ack_flag_next = 1'b0;
                end
                ahc_pkg::PH_WDONE: begin
                    if (item.send_done) begin
                        phase_next = ahc_pkg::PH_ACQ;
                    end
                end
                default: begin
                    phase_next = ahc_pkg::PH_IDLE;
                end
            endcase
            if (item.req_type == ahc_pkg::REQ_RESET) begin
                phase_next = ahc_pkg::PH_IDLE;
            end
        end
    end

    always_comb begin
        result.ready_level      = ready_next;
        result.capture_stop     = cap_stop;
        result.capture_start    = cap_start;
        result.buffer_swap      = swap;
        result.send_request     = send_req;
        result.send_seq         = send_req ? seq_reg : '0;
        result.running          = run_next;
        result.phase            = phase_next;
        result.miss_ready_count = miss_rdy_total_next;
        result.miss_ack_count   = miss_ack_total_next;
    end

    assign run_flag = run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= ahc_pkg::PH_IDLE;
            last_time_reg      <= '0;
            start_pend_reg     <= 1'b0;
            stop_pend_reg      <= 1'b0;
            run_reg            <= 1'b0;
            ready_reg          <= 1'b0;
            miss_rdy_flag_reg  <= 1'b0;
            miss_ack_flag_reg  <= 1'b0;
            miss_rdy_total_reg <= '0;
            miss_ack_total_reg <= '0;
            seq_reg            <= '0;
        end else if (advance) begin
            phase_reg          <= phase_next;
            last_time_reg      <= last_time_next;
            start_pend_reg     <= start_pend_next;
            stop_pend_reg      <= stop_pend_next;
            run_reg            <= run_next;
            ready_reg          <= ready_next;
            miss_rdy_flag_reg  <= miss_rdy_flag_next;
            miss_ack_flag_reg  <= miss_ack_flag_next;
            miss_rdy_total_reg <= miss_rdy_total_next;
            miss_ack_total_reg <= miss_ack_total_next;
            seq_reg            <= seq_next;
        end
    end

`ifndef SYNTH
    a_send_enters_wdone: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.send_request && item.req_type != ahc_pkg::REQ_RESET
        |=> phase_reg == ahc_pkg::PH_WDONE)
        else $error("send request did not move to wait-done");

    a_seq_only_on_send: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && result.send_request) |=> $stable(seq_reg))
        else $error("sequence counter moved without a send request");

    a_miss_rdy_from_wready: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(miss_rdy_flag_reg) |-> $past(phase_reg) == ahc_pkg::PH_WREADY)
        else $error("ready miss flagged outside wait-ready");

    a_miss_ack_from_wack: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(miss_ack_flag_reg) |-> $past(phase_reg) == ahc_pkg::PH_WACK)
        else $error("ack miss flagged outside wait-ack");
`endif

endmodule

>>> design/acquisition_handshake_controller.sv
// Acquisition handshake controller: input beat register, step logic, result register.
// A beat accepted into the input register has its result registered in the result register, then shown on m_*.
// Throughput: one beat per cycle while m_ready is high; the input register refills as the result register drains.
// Reset (aresetn low, synchronous): both registers empty, phase idle, counters zero,
// period back to 20000 us. Depends on ahc_pkg and ahc_fsm.
module acquisition_handshake_controller #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [ahc_pkg::PERIOD_W-1:0]      cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [ahc_pkg::TIME_IN_W-1:0]     s_time_us,
    input  logic                              s_host_send,
    input  logic                              s_send_done,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_ready_level,
    output logic                              m_capture_stop,
    output logic                              m_capture_start,
    output logic                              m_buffer_swap,
    output logic                              m_send_request,
    output logic [ahc_pkg::CNT_W-1:0]         m_send_seq,
    output logic                              m_running,
    output logic [2:0]                        m_phase,
    output logic [ahc_pkg::CNT_W-1:0]         m_miss_ready_count,
    output logic [ahc_pkg::CNT_W-1:0]         m_miss_ack_count
);

    logic                          in_valid_reg;
    ahc_pkg::item_t                in_item_reg;
    logic                          out_valid_reg;
    ahc_pkg::result_t              out_res_reg;
    logic [ahc_pkg::PERIOD_W-1:0]  period_reg;
    logic                          advance;
    logic                          run_flag;
    ahc_pkg::result_t              step_res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.req_type  <= ahc_pkg::req_t'(s_req_type);
            in_item_reg.time_us   <= s_time_us;
            in_item_reg.host_send <= s_host_send;
            in_item_reg.send_done <= s_send_done;
        end
    end

    ahc_fsm #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_fsm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .item     (in_item_reg),
        .period   (period_reg),
        .result   (step_res),
        .run_flag (run_flag)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    // period writes are dropped during a run or when out of range
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= ahc_pkg::PERIOD_RESET;
        end else if (cfg_wr_en && !run_flag && cfg_wr_data >= ahc_pkg::PERIOD_MIN
                     && cfg_wr_data <= ahc_pkg::PERIOD_MAX) begin
            period_reg <= cfg_wr_data;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_ready_level      = out_res_reg.ready_level;
    assign m_capture_stop     = out_res_reg.capture_stop;
    assign m_capture_start    = out_res_reg.capture_start;
    assign m_buffer_swap      = out_res_reg.buffer_swap;
    assign m_send_request     = out_res_reg.send_request;
    assign m_send_seq         = out_res_reg.send_seq;
    assign m_running          = out_res_reg.running;
    assign m_phase            = out_res_reg.phase;
    assign m_miss_ready_count = out_res_reg.miss_ready_count;
    assign m_miss_ack_count   = out_res_reg.miss_ack_count;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for acquisition_handshake_controller: directed request sequences,
// then randomized run/slot/handshake traffic, each result beat checked against an in-bench model.
// Depends on ahc_pkg and the design sources.
module tb_top;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int TAIL_CYCLES     = 8;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [ahc_pkg::PERIOD_W-1:0]  cfg_wr_data = '0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    logic [1:0]                    s_req_type  = ahc_pkg::REQ_TICK;
    logic [ahc_pkg::TIME_IN_W-1:0] s_time_us   = '0;
    logic                          s_host_send = 1'b0;
    logic                          s_send_done = 1'b0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic                          m_ready_level;
    logic                          m_capture_stop;
    logic                          m_capture_start;
    logic                          m_buffer_swap;
    logic                          m_send_request;
    logic [ahc_pkg::CNT_W-1:0]     m_send_seq;
    logic                          m_running;
    logic [2:0]                    m_phase;
    logic [ahc_pkg::CNT_W-1:0]     m_miss_ready_count;
    logic [ahc_pkg::CNT_W-1:0]     m_miss_ack_count;

    acquisition_handshake_controller u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_time_us          (s_time_us),
        .s_host_send        (s_host_send),
        .s_send_done        (s_send_done),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_ready_level      (m_ready_level),
        .m_capture_stop     (m_capture_stop),
        .m_capture_start    (m_capture_start),
        .m_buffer_swap      (m_buffer_swap),
        .m_send_request     (m_send_request),
        .m_send_seq         (m_send_seq),
        .m_running          (m_running),
        .m_phase            (m_phase),
        .m_miss_ready_count (m_miss_ready_count),
        .m_miss_ack_count   (m_miss_ack_count)
    );

    always #4 aclk = ~aclk;

    // Model of the pacing controller
    logic [ahc_pkg::PERIOD_W-1:0]  mdl_period         = ahc_pkg::PERIOD_RESET;
    ahc_pkg::phase_t               mdl_phase          = ahc_pkg::PH_IDLE;
    logic [ahc_pkg::TIME_IN_W-1:0] mdl_last_capture   = '0;
    logic                          mdl_start_pend     = 1'b0;
    logic                          mdl_stop_pend      = 1'b0;
    logic                          mdl_running        = 1'b0;
    logic                          mdl_ready          = 1'b0;
    logic                          mdl_miss_rdy_flag  = 1'b0;
    logic                          mdl_miss_ack_flag  = 1'b0;
    logic [ahc_pkg::CNT_W-1:0]     mdl_miss_rdy_total = '0;
    logic [ahc_pkg::CNT_W-1:0]     mdl_miss_ack_total = '0;
    logic [ahc_pkg::CNT_W-1:0]     mdl_seq            = '0;

    ahc_pkg::result_t              expected_q[$];
    ahc_pkg::result_t              want;
    logic [ahc_pkg::TIME_IN_W-1:0] now_us = '0;
    bit                   src_gaps    = 1'b1;
    bit                   sink_stalls = 1'b1;
    int                   mismatch_count = 0;
    int                   beats_sent     = 0;
    int                   results_seen   = 0;
    int                   sends_seen     = 0;
    int                   writes_done    = 0;
    int                   quiet_cycles   = 0;

    // elapsed time uses wrapping subtraction
    function automatic logic slot_elapsed_over(input logic [31:0] now, input logic [31:0] lim);
        return (now - mdl_last_capture) > lim;
    endfunction

    task automatic pacing_tick(input logic [31:0] now, input logic hs, input logic sd,
                               inout ahc_pkg::result_t r);
        logic [31:0] twice;
        twice = {7'd0, mdl_period, 1'b0};
        case (mdl_phase)
            ahc_pkg::PH_IDLE: begin
                mdl_running = 1'b0;
                if (mdl_start_pend) begin
                    mdl_phase      = ahc_pkg::PH_ACQ;
                    mdl_running    = 1'b1;
                    mdl_start_pend = 1'b0;
                end
                if (mdl_stop_pend) begin
                    mdl_stop_pend = 1'b0;
                    mdl_running   = 1'b0;
                end
            end
            ahc_pkg::PH_ACQ: begin
                if (mdl_stop_pend) begin
                    mdl_phase     = ahc_pkg::PH_IDLE;
                    mdl_stop_pend = 1'b0;
                end else if (slot_elapsed_over(now, 32'(mdl_period))) begin
                    r.capture_stop = 1'b1;
                    mdl_phase      = ahc_pkg::PH_WREADY;
                end
            end
            ahc_pkg::PH_WREADY: begin
                if (!hs) begin
                    mdl_phase = ahc_pkg::PH_WACK;
                end else if (!mdl_miss_rdy_flag && slot_elapsed_over(now, twice)) begin
                    mdl_miss_rdy_flag = 1'b1;
                    mdl_miss_rdy_total++;
                end
            end
            ahc_pkg::PH_WACK: begin
                mdl_ready = 1'b1;
                if (hs) begin
                    mdl_ready = 1'b0;
                    mdl_phase = ahc_pkg::PH_SEND;
                end else if (!mdl_miss_ack_flag && slot_elapsed_over(now, twice)) begin
                    mdl_miss_ack_flag = 1'b1;
                    mdl_miss_ack_total++;
                end
            end
            ahc_pkg::PH_SEND: begin
                r.buffer_swap     = 1'b1;
                r.capture_start   = 1'b1;
                r.send_request    = 1'b1;
                r.send_seq        = mdl_seq;
                mdl_last_capture  = now;
                mdl_seq++;
                mdl_phase         = ahc_pkg::PH_WDONE;
                mdl_miss_rdy_flag = 1'b0;
                mdl_miss_ack_flag = 1'b0;
            end
            ahc_pkg::PH_WDONE: begin
                if (sd) mdl_phase = ahc_pkg::PH_ACQ;
            end
            default: mdl_phase = ahc_pkg::PH_IDLE;
        endcase
    endtask

    task automatic predict_beat(input ahc_pkg::item_t b, output ahc_pkg::result_t r);
        r = '0;
        case (b.req_type)
            ahc_pkg::REQ_TICK: pacing_tick(b.time_us, b.host_send, b.send_done, r);
            ahc_pkg::REQ_START: begin
                mdl_last_capture = b.time_us;
                mdl_start_pend   = 1'b1;
                r.capture_start  = 1'b1;
            end
            ahc_pkg::REQ_STOP: mdl_stop_pend = 1'b1;
            default: begin
                // reset request: one tick with stop pending, then forced idle
                mdl_stop_pend = 1'b1;
                pacing_tick(b.time_us, b.host_send, b.send_done, r);
                mdl_phase = ahc_pkg::PH_IDLE;
            end
        endcase
        r.ready_level      = mdl_ready;
        r.running          = mdl_running;
        r.phase            = mdl_phase;
        r.miss_ready_count = mdl_miss_rdy_total;
        r.miss_ack_count   = mdl_miss_ack_total;
    endtask

    task automatic send_beat(input ahc_pkg::req_t rq, input logic [31:0] t, input logic hs,
                             input logic sd);
        ahc_pkg::item_t   beat;
        ahc_pkg::result_t r;
        while (src_gaps && $urandom_range(0, 99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        beat.req_type  = rq;
        beat.time_us   = t;
        beat.host_send = hs;
        beat.send_done = sd;
        s_valid     <= 1'b1;
        s_req_type  <= rq;
        s_time_us   <= t;
        s_host_send <= hs;
        s_send_done <= sd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_beat(beat, r);
        expected_q.push_back(r);
        beats_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_period(input logic [ahc_pkg::PERIOD_W-1:0] v);
        drain_results();
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        // writes are dropped while running or outside the legal range
        if (!mdl_running && v >= ahc_pkg::PERIOD_MIN && v <= ahc_pkg::PERIOD_MAX)
            mdl_period = v;
        writes_done++;
    endtask

    // reset requests until the controller sits in idle with nothing pending
    task automatic park_idle();
        while (mdl_running || mdl_phase != ahc_pkg::PH_IDLE || mdl_start_pend
               || mdl_stop_pend)
            send_beat(ahc_pkg::REQ_RESET, now_us, 1'b1, 1'b0);
    endtask

    task automatic test_idle_requests();
        send_beat(ahc_pkg::REQ_TICK, 32'h0000_0000, 1'b0, 1'b0);
        send_beat(ahc_pkg::REQ_STOP, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_beat(ahc_pkg::REQ_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_beat(ahc_pkg::REQ_RESET, 32'h0000_0000, 1'b0, 1'b1);
    endtask

    task automatic test_slot_handshake();
        logic [31:0] t0;
        t0 = 32'hFFFF_FF00;
        send_beat(ahc_pkg::REQ_START, t0, 1'b0, 1'b0);
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd5, 1'b0, 1'b0);      // start consumed
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd20000, 1'b1, 1'b0);  // exactly one period: still open
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd20001, 1'b1, 1'b0);  // closes across the time wrap
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd40001, 1'b1, 1'b0);  // missed ready
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd50000, 1'b1, 1'b1);  // counted once only
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd50001, 1'b0, 1'b0);
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd60000, 1'b0, 1'b1);  // READY up, missed ack
        send_beat(ahc_pkg::REQ_STOP, t0 + 32'd60001, 1'b0, 1'b0);  // held until acquiring
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd60002, 1'b1, 1'b0);
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd60003, 1'b1, 1'b1);  // send beat
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd60004, 1'b0, 1'b0);
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd60005, 1'b0, 1'b1);
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd60006, 1'b0, 1'b0);  // pending stop taken
        send_beat(ahc_pkg::REQ_TICK, t0 + 32'd60007, 1'b0, 1'b0);
    endtask

    task automatic test_start_stop_pending();
        send_beat(ahc_pkg::REQ_START, 32'd100, 1'b0, 1'b0);
        send_beat(ahc_pkg::REQ_STOP, 32'd101, 1'b0, 1'b0);
        send_beat(ahc_pkg::REQ_TICK, 32'd102, 1'b1, 1'b1);         // acquiring but not running
        send_beat(ahc_pkg::REQ_TICK, 32'd20101, 1'b1, 1'b0);
        send_beat(ahc_pkg::REQ_RESET, 32'd20102, 1'b1, 1'b0);
    endtask

    task automatic test_period_register();
        park_idle();
        write_period(ahc_pkg::PERIOD_MIN);
        write_period('0);
        write_period('1);
        write_period(ahc_pkg::PERIOD_MAX + 1'b1);
        write_period(ahc_pkg::PERIOD_MAX);
        now_us = $urandom();
        send_beat(ahc_pkg::REQ_START, now_us, 1'b0, 1'b0);
        send_beat(ahc_pkg::REQ_TICK, now_us + 32'd1, 1'b0, 1'b0);
        write_period(24'd5);                                  // dropped: running
        send_beat(ahc_pkg::REQ_TICK, now_us + 32'(ahc_pkg::PERIOD_MAX), 1'b1, 1'b0);
        send_beat(ahc_pkg::REQ_TICK, now_us + 32'(ahc_pkg::PERIOD_MAX) + 32'd1, 1'b1, 1'b0);
        park_idle();
    endtask

    task automatic test_random_traffic(input logic [ahc_pkg::PERIOD_W-1:0] period,
                                       input int n_beats, input bit gaps, input bit stalls);
        int unsigned   roll;
        logic [31:0]   span;
        ahc_pkg::req_t rq;
        logic          hs;
        logic          sd;
        park_idle();
        write_period(period);
        src_gaps    = gaps;
        sink_stalls = stalls;
        now_us      = $urandom();
        for (int i = 0; i < n_beats; i++) begin
            roll   = $urandom_range(0, 99);
            span   = (roll < 20) ? 32'(mdl_period) * 32'd3 : 32'(mdl_period);
            now_us = now_us + $urandom_range(0, span);
            if ($urandom_range(0, 99) < 4) begin
                send_beat(ahc_pkg::req_t'(2'($urandom_range(0, 3))), $urandom(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                roll = $urandom_range(0, 99);
                if (mdl_phase == ahc_pkg::PH_IDLE)
                    rq = (roll < 40) ? ahc_pkg::REQ_START : ahc_pkg::REQ_TICK;
                else if (roll < 3) rq = ahc_pkg::REQ_STOP;
                else if (roll < 5) rq = ahc_pkg::REQ_RESET;
                else if (roll < 7) rq = ahc_pkg::REQ_START;
                else rq = ahc_pkg::REQ_TICK;
                // bias the host lines so handshakes linger and slots get missed
                hs = 1'($urandom_range(0, 1));
                if (mdl_phase == ahc_pkg::PH_WREADY) hs = $urandom_range(0, 99) < 65;
                else if (mdl_phase == ahc_pkg::PH_WACK) hs = $urandom_range(0, 99) >= 65;
                sd = (mdl_phase == ahc_pkg::PH_WDONE) ? ($urandom_range(0, 99) < 35)
                                                      : 1'($urandom_range(0, 1));
                send_beat(rq, now_us, hs, sd);
            end
            if ($urandom_range(0, 199) == 0) drain_results();
        end
        drain_results();
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    always @(posedge aclk) begin
        m_ready <= sink_stalls ? ($urandom_range(0, 99) >= 26) : 1'b1;
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                $error("result beat with no expected result pending");
                mismatch_count++;
            end else begin
                want = expected_q.pop_front();
                results_seen++;
                if (want.send_request) sends_seen++;
                check_field("ready_level", 32'(want.ready_level), 32'(m_ready_level));
                check_field("capture_stop", 32'(want.capture_stop), 32'(m_capture_stop));
                check_field("capture_start", 32'(want.capture_start), 32'(m_capture_start));
                check_field("buffer_swap", 32'(want.buffer_swap), 32'(m_buffer_swap));
                check_field("send_request", 32'(want.send_request), 32'(m_send_request));
                check_field("send_seq", want.send_seq, m_send_seq);
                check_field("running", 32'(want.running), 32'(m_running));
                check_field("phase", 32'(want.phase), 32'(m_phase));
                check_field("miss_ready_count", want.miss_ready_count, m_miss_ready_count);
                check_field("miss_ack_count", want.miss_ack_count, m_miss_ack_count);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $error("no handshake for %0d cycles, %0d results outstanding",
                   quiet_cycles, expected_q.size());
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_requests();
        test_slot_handshake();
        test_start_stop_pending();
        test_period_register();

        test_random_traffic(ahc_pkg::PERIOD_MIN, 300, 1'b1, 1'b1);
        test_random_traffic(24'd2, 300, 1'b1, 1'b1);
        test_random_traffic(24'd13, 300, 1'b0, 1'b0);        // back-to-back, no idling
        test_random_traffic(ahc_pkg::PERIOD_W'($urandom_range(3, 500)), 300, 1'b1, 1'b1);
        test_random_traffic(ahc_pkg::PERIOD_MAX, 300, 1'b1, 1'b1);
        test_random_traffic(ahc_pkg::PERIOD_W'($urandom_range(1, 10000000)), 300,
                            1'b1, 1'b1);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_q.size() != 0) begin
            $error("%0d expected results never arrived", expected_q.size());
            mismatch_count++;
        end

        $display("Covered %0d request beats, %0d result beats, %0d send requests.",
                 beats_sent, results_seen, sends_seen);
        $display("Period writes: %0d; missed ready/ack slots at end: %0d/%0d.",
                 writes_done, mdl_miss_rdy_total, mdl_miss_ack_total);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ahc_pkg.sv
design/ahc_fsm.sv
design/acquisition_handshake_controller.sv
tb/tb_top.sv
